// ===== rtl/segment_box_slab_clip_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment/box slab clipper
// Shared property wrappers, sampled on the rising clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_SLAB_CLIP_CORE_DEFINES_SVH
`define SEGMENT_BOX_SLAB_CLIP_CORE_DEFINES_SVH

// same-cycle implication
`define SBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbc assertion failed");

// next-cycle implication
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbc assertion failed");

`endif

// ===== rtl/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Widths, constants and stage types of the segment/box slab clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 16;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int NUM_W         = DIFF_W + FRACTION_BITS;
    localparam int QUO_W         = FRACTION_BITS + 2;
    localparam int T_W           = QUO_W + 1;
    localparam int FRAC_OUT_W    = FRACTION_BITS + 1;
    localparam int PROD_W        = DIFF_W + T_W;
    localparam int DIV_LAT       = QUO_W + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [NUM_W-1:0]      t_num;
    typedef logic signed [T_W-1:0]        t_tval;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic [FRAC_OUT_W-1:0]        t_frac;

    localparam t_tval T_ZERO = '0;
    localparam t_tval T_ONE  = t_tval'(64'd1 << FRACTION_BITS);

    typedef struct packed {
        logic [DIFF_W-1:0] rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  q;
        logic              neg;
        logic              ovf;
        logic [DIFF_W-1:0] den;
    } t_div_stage;

    typedef struct packed {
        logic   valid;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        t_coord minx;
        t_coord miny;
        t_coord maxx;
        t_coord maxy;
    } t_in_stage;

    typedef struct packed {
        logic   valid;
        t_coord sx;
        t_coord sy;
        t_diff  dx;
        t_diff  dy;
        logic   par_x;
        logic   par_y;
        logic   in_x;
        logic   in_y;
    } t_side;

    typedef struct packed {
        logic   valid;
        logic   miss;
        t_tval  lo;
        t_tval  hi;
        t_tval  ty0;
        t_tval  ty1;
        logic   par_y;
        logic   in_y;
        t_coord sx;
        t_coord sy;
        t_diff  dx;
        t_diff  dy;
    } t_cx;

    typedef struct packed {
        logic   valid;
        logic   hit;
        t_tval  lo;
        t_coord sx;
        t_coord sy;
        t_diff  dx;
        t_diff  dy;
    } t_cy;

    typedef struct packed {
        logic   valid;
        logic   hit;
        t_tval  lo;
        t_coord sx;
        t_coord sy;
        t_prod  px;
        t_prod  py;
    } t_mul;

    typedef struct packed {
        logic   valid;
        logic   hit;
        t_coord hx;
        t_coord hy;
        t_frac  frac;
    } t_out_stage;

endpackage

`default_nettype wire

// ===== rtl/sbc_if.sv =====
// ----------------------------------------------------------------------------
// sbc_in_if / sbc_out_if
// Valid/ready channels carrying one segment-box item and one clip result.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_in_if;
    import sbc_pkg::*;
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;
    t_coord box_min_x;
    t_coord box_min_y;
    t_coord box_max_x;
    t_coord box_max_y;

    modport source (
        output valid, start_x, start_y, end_x, end_y,
               box_min_x, box_min_y, box_max_x, box_max_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y,
               box_min_x, box_min_y, box_max_x, box_max_y,
        output ready
    );
endinterface

interface sbc_out_if;
    import sbc_pkg::*;
    logic   valid;
    logic   ready;
    logic   hit;
    t_coord hit_x;
    t_coord hit_y;
    t_frac  hit_fraction;

    modport source (
        output valid, hit, hit_x, hit_y, hit_fraction,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_x, hit_y, hit_fraction,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/segment_box_slab_clip_core.sv =====
// ----------------------------------------------------------------------------
// segment_box_slab_clip_core
// Liang-Barsky clip of one segment against one axis-aligned box per item.
//
//   channel | dir | payload
//   i_in    | in  | start, end, box min/max (x, y), signed Q12.4
//   o_out   | out | hit, hit_x, hit_y (Q12.4), hit_fraction (Q1.16)
//
// One item per cycle while the output is not stalled. Stages: input register,
// four floor dividers of FRACTION_BITS+2 bit stages, two clip, multiply, output.
// Synchronous active-low reset clears all valid bits.
// The whole pipe advances when the output register is empty or taken;
// a stall holds every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_slab_clip_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbc_in_if.sink     i_in,
    sbc_out_if.source  o_out
);
    import sbc_pkg::*;

    logic        en;
    t_in_stage   n_s0, r_s0;
    t_side       n_side;
    t_side       r_side [0:DIV_LAT-1];
    t_diff       dx, dy;
    t_num        num_x0, num_x1, num_y0, num_y1;
    t_tval       qx0, qx1, qy0, qy1;
    t_cy         cy;
    t_out_stage  res;

    assign en         = !res.valid || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        n_s0.valid = i_in.valid;
        n_s0.sx    = i_in.start_x;
        n_s0.sy    = i_in.start_y;
        n_s0.ex    = i_in.end_x;
        n_s0.ey    = i_in.end_y;
        n_s0.minx  = i_in.box_min_x;
        n_s0.miny  = i_in.box_min_y;
        n_s0.maxx  = i_in.box_max_x;
        n_s0.maxy  = i_in.box_max_y;
    end

    always_comb begin
        dx     = t_diff'(r_s0.ex) - t_diff'(r_s0.sx);
        dy     = t_diff'(r_s0.ey) - t_diff'(r_s0.sy);
        num_x0 = $signed({t_diff'(t_diff'(r_s0.minx) - t_diff'(r_s0.sx)),
                          {FRACTION_BITS{1'b0}}});
        num_x1 = $signed({t_diff'(t_diff'(r_s0.maxx) - t_diff'(r_s0.sx)),
                          {FRACTION_BITS{1'b0}}});
        num_y0 = $signed({t_diff'(t_diff'(r_s0.miny) - t_diff'(r_s0.sy)),
                          {FRACTION_BITS{1'b0}}});
        num_y1 = $signed({t_diff'(t_diff'(r_s0.maxy) - t_diff'(r_s0.sy)),
                          {FRACTION_BITS{1'b0}}});
        n_side.valid = r_s0.valid;
        n_side.sx    = r_s0.sx;
        n_side.sy    = r_s0.sy;
        n_side.dx    = dx;
        n_side.dy    = dy;
        n_side.par_x = (dx == '0);
        n_side.par_y = (dy == '0);
        n_side.in_x  = (r_s0.minx <= r_s0.sx) && (r_s0.sx <= r_s0.maxx);
        n_side.in_y  = (r_s0.miny <= r_s0.sy) && (r_s0.sy <= r_s0.maxy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_s0      <= n_s0;
            r_side[0] <= n_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    sbc_div u_div_x0 (.i_clk(i_clk), .i_en(en), .i_num(num_x0), .i_den(dx), .o_quo(qx0));
    sbc_div u_div_x1 (.i_clk(i_clk), .i_en(en), .i_num(num_x1), .i_den(dx), .o_quo(qx1));
    sbc_div u_div_y0 (.i_clk(i_clk), .i_en(en), .i_num(num_y0), .i_den(dy), .o_quo(qy0));
    sbc_div u_div_y1 (.i_clk(i_clk), .i_en(en), .i_num(num_y1), .i_den(dy), .o_quo(qy1));

    sbc_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_side[DIV_LAT-1]),
        .i_qx0   (qx0),
        .i_qx1   (qx1),
        .i_qy0   (qy0),
        .i_qy1   (qy1),
        .o_cy    (cy)
    );

    sbc_entry u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cy    (cy),
        .o_out   (res)
    );

    assign o_out.valid        = res.valid;
    assign o_out.hit          = res.hit;
    assign o_out.hit_x        = res.hx;
    assign o_out.hit_y        = res.hy;
    assign o_out.hit_fraction = res.frac;

endmodule

`default_nettype wire

// ===== rtl/sbc_div.sv =====
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined floor divider, one quotient bit per stage, saturating quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_div (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire sbc_pkg::t_num  i_num,
    input  wire sbc_pkg::t_diff i_den,
    output sbc_pkg::t_tval      o_quo
);
    import sbc_pkg::*;

    function automatic t_div_stage div_step(t_div_stage s);
        logic [DIFF_W:0] trial;
        logic            ge;
        t_div_stage      n;
        trial = {s.rem, s.low[QUO_W-1]};
        ge    = trial >= {1'b0, s.den};
        n     = s;
        n.rem = ge ? DIFF_W'(trial - {1'b0, s.den}) : DIFF_W'(trial);
        n.low = s.low << 1;
        n.q   = {s.q[QUO_W-2:0], ge};
        return n;
    endfunction

    logic [NUM_W-1:0]       num_mag;
    logic [DIFF_W-1:0]      den_mag;
    t_div_stage             n_st0;
    t_div_stage             r_st [0:QUO_W];
    t_tval                  n_quo;
    t_tval                  r_quo;
    logic [QUO_W:0]         q_adj;

    always_comb begin
        num_mag      = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        den_mag      = i_den[DIFF_W-1] ? DIFF_W'(-i_den) : DIFF_W'(i_den);
        n_st0.rem    = DIFF_W'(num_mag[NUM_W-1:QUO_W]);
        n_st0.low    = num_mag[QUO_W-1:0];
        n_st0.q      = '0;
        n_st0.neg    = i_num[NUM_W-1] ^ i_den[DIFF_W-1];
        n_st0.ovf    = DIFF_W'(num_mag[NUM_W-1:QUO_W]) >= den_mag;
        n_st0.den    = den_mag;
    end

    always_comb begin
        q_adj = {1'b0, r_st[QUO_W].q} + (QUO_W+1)'(|r_st[QUO_W].rem);
        if (r_st[QUO_W].ovf) begin
            n_quo = r_st[QUO_W].neg ? {1'b1, {QUO_W{1'b0}}} : {1'b0, {QUO_W{1'b1}}};
        end else if (r_st[QUO_W].neg) begin
            n_quo = -$signed(q_adj);
        end else begin
            n_quo = $signed({1'b0, r_st[QUO_W].q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
            for (int k = 0; k < QUO_W; k++) begin
                r_st[k+1] <= div_step(r_st[k]);
            end
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

// ===== rtl/sbc_clip.sv =====
// ----------------------------------------------------------------------------
// sbc_clip
// Slab interval narrowing, X stage then Y stage, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_clip (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire sbc_pkg::t_side  i_side,
    input  wire sbc_pkg::t_tval  i_qx0,
    input  wire sbc_pkg::t_tval  i_qx1,
    input  wire sbc_pkg::t_tval  i_qy0,
    input  wire sbc_pkg::t_tval  i_qy1,
    output sbc_pkg::t_cy         o_cy
);
    import sbc_pkg::*;

    t_cx   n_cx, r_cx;
    t_cy   n_cy, r_cy;
    t_tval t0, t1, u0, u1, lo_y, hi_y;

    always_comb begin
        t0 = (i_qx0 > i_qx1) ? i_qx1 : i_qx0;
        t1 = (i_qx0 > i_qx1) ? i_qx0 : i_qx1;
        n_cx.valid = i_side.valid;
        n_cx.ty0   = (i_qy0 > i_qy1) ? i_qy1 : i_qy0;
        n_cx.ty1   = (i_qy0 > i_qy1) ? i_qy0 : i_qy1;
        n_cx.par_y = i_side.par_y;
        n_cx.in_y  = i_side.in_y;
        n_cx.sx    = i_side.sx;
        n_cx.sy    = i_side.sy;
        n_cx.dx    = i_side.dx;
        n_cx.dy    = i_side.dy;
        if (i_side.par_x) begin
            n_cx.miss = !i_side.in_x;
            n_cx.lo   = T_ZERO;
            n_cx.hi   = T_ONE;
        end else begin
            n_cx.lo   = (t0 > T_ZERO) ? t0 : T_ZERO;
            n_cx.hi   = (t1 < T_ONE) ? t1 : T_ONE;
            n_cx.miss = (t1 < T_ZERO) || (t0 > T_ONE) ||
                        (((t0 > T_ZERO) ? t0 : T_ZERO) > ((t1 < T_ONE) ? t1 : T_ONE));
        end
    end

    always_comb begin
        u0    = r_cx.ty0;
        u1    = r_cx.ty1;
        lo_y  = (u0 > r_cx.lo) ? u0 : r_cx.lo;
        hi_y  = (u1 < r_cx.hi) ? u1 : r_cx.hi;
        n_cy.valid = r_cx.valid;
        n_cy.sx    = r_cx.sx;
        n_cy.sy    = r_cx.sy;
        n_cy.dx    = r_cx.dx;
        n_cy.dy    = r_cx.dy;
        if (r_cx.par_y) begin
            n_cy.hit = !r_cx.miss && r_cx.in_y;
            n_cy.lo  = r_cx.lo;
        end else begin
            n_cy.hit = !r_cx.miss && !(u1 < r_cx.lo) && !(u0 > r_cx.hi) && (lo_y <= hi_y);
            n_cy.lo  = lo_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx.valid <= 1'b0;
            r_cy.valid <= 1'b0;
        end else if (i_en) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    assign o_cy = r_cy;

endmodule

`default_nettype wire

// ===== rtl/sbc_entry.sv =====
// ----------------------------------------------------------------------------
// sbc_entry
// Entry point: multiply stage, then truncate-and-add into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_entry (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire sbc_pkg::t_cy      i_cy,
    output sbc_pkg::t_out_stage    o_out
);
    import sbc_pkg::*;

    localparam t_prod BIAS = t_prod'((64'd1 << FRACTION_BITS) - 64'd1);

    t_mul       n_mul, r_mul;
    t_out_stage n_out, r_out;
    t_prod      bx, by, sum_x, sum_y;

    always_comb begin
        n_mul.valid = i_cy.valid;
        n_mul.hit   = i_cy.hit;
        n_mul.lo    = i_cy.lo;
        n_mul.sx    = i_cy.sx;
        n_mul.sy    = i_cy.sy;
        n_mul.px    = t_prod'(i_cy.dx) * t_prod'(i_cy.lo);
        n_mul.py    = t_prod'(i_cy.dy) * t_prod'(i_cy.lo);
    end

    always_comb begin
        bx    = r_mul.px + (r_mul.px[PROD_W-1] ? BIAS : '0);
        by    = r_mul.py + (r_mul.py[PROD_W-1] ? BIAS : '0);
        sum_x = t_prod'(r_mul.sx) + (bx >>> FRACTION_BITS);
        sum_y = t_prod'(r_mul.sy) + (by >>> FRACTION_BITS);
        n_out.valid = r_mul.valid;
        n_out.hit   = r_mul.hit;
        n_out.hx    = r_mul.hit ? sum_x[COORD_BITS-1:0] : '0;
        n_out.hy    = r_mul.hit ? sum_y[COORD_BITS-1:0] : '0;
        n_out.frac  = r_mul.hit ? r_mul.lo[FRAC_OUT_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul.valid <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_mul <= n_mul;
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== rtl/sbc_checker.sv =====
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks of the slab clipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_box_slab_clip_core_defines.svh"

module sbc_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic                 i_out_hit,
    input wire sbc_pkg::t_coord      i_out_hit_x,
    input wire sbc_pkg::t_coord      i_out_hit_y,
    input wire sbc_pkg::t_frac       i_out_frac
);
    import sbc_pkg::*;

    localparam t_frac FRAC_ONE = t_frac'(64'd1 << FRACTION_BITS);

    `SBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `SBC_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_out_valid && !i_out_hit, (i_out_hit_x == '0) && (i_out_hit_y == '0) && (i_out_frac == '0))
    `SBC_ASSERT_NOW(a_frac_range, i_clk, i_rst_n, i_out_valid && i_out_hit, i_out_frac <= FRAC_ONE)
    `SBC_ASSERT_NOW(a_ready_on_take, i_clk, i_rst_n, i_out_ready, i_in_ready)

endmodule

bind segment_box_slab_clip_core sbc_checker u_sbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.hit),
    .i_out_hit_x (o_out.hit_x),
    .i_out_hit_y (o_out.hit_y),
    .i_out_frac  (o_out.hit_fraction)
);

`default_nettype wire
